/* rtl/order_size_bucket_statistics_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef ORDER_SIZE_BUCKET_STATISTICS_ASSERT_SVH
`define ORDER_SIZE_BUCKET_STATISTICS_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is held
`define OSBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held
`define OSBS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/osbs_pkg.sv */
package osbs_pkg;

    localparam int STAT_W      = 32;
    localparam int NUM_CLASSES = 4;
    localparam int NUM_STATS   = 12;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = NUM_STATS * STAT_W;

    // Bit offsets of the side counters inside m_tdata
    localparam int BUY_CNT_LSB  = 8 * STAT_W;
    localparam int SELL_CNT_LSB = 9 * STAT_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VOL_SMALL  = 3'd0,
        REG_VOL_MEDIUM = 3'd1,
        REG_VOL_LARGE  = 3'd2,
        REG_AMT_SMALL  = 3'd3,
        REG_AMT_MEDIUM = 3'd4,
        REG_AMT_LARGE  = 3'd5
    } cfg_index_t;

    localparam logic [31:0] VOL_SMALL_RST  = 32'd20000;
    localparam logic [31:0] VOL_MEDIUM_RST = 32'd100000;
    localparam logic [31:0] VOL_LARGE_RST  = 32'd500000;
    localparam logic [31:0] AMT_SMALL_RST  = 32'd40000;
    localparam logic [31:0] AMT_MEDIUM_RST = 32'd100000;
    localparam logic [31:0] AMT_LARGE_RST  = 32'd1000000;

    // Ten digits already bring any 32-bit amount to zero
    localparam logic [7:0]  DIGIT_LIMIT = 8'd10;
    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        ACT_ORDER    = 2'd0,
        ACT_WITHDRAW = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // One classified item on its way from the front to the back
    typedef struct packed {
        action_t     action;
        logic        sell;
        logic        split;
        logic [1:0]  cls;
        logic [31:0] volume;
    } op_t;

endpackage

/* rtl/osbs_front.sv */
module osbs_front import osbs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic signed [1:0]      s_direction,
    input  logic [31:0]            s_price,
    input  logic [31:0]            s_volume,
    input  logic [7:0]             s_digits,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output logic                   push_valid,
    output op_t                    push_op,
    input  logic                   push_ready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [31:0]  amount_reg, amount_next;
    logic [3:0]   digit_cnt_reg, digit_cnt_next;
    op_t          op_reg, op_next;

    logic [31:0] vol_small_reg, vol_medium_reg, vol_large_reg;
    logic [31:0] amt_small_reg, amt_medium_reg, amt_large_reg;

    logic [31:0] amount_mul;
    logic [63:0] recip_prod;
    logic [31:0] amount_div;
    logic [3:0]  digit_start;
    logic [1:0]  cls;

    // Wrapped product, then one divide by ten per step
    assign amount_mul = s_price * s_volume;
    assign recip_prod = 64'(amount_reg) * 64'(RECIP_TEN);
    assign amount_div = {{RECIP_SHIFT - 32{1'b0}}, recip_prod[63:RECIP_SHIFT]};

    // Clamp the digit count; only orders need the scaled amount
    always_comb begin
        if (action_t'(s_action) != ACT_ORDER) begin
            digit_start = '0;
        end else if (s_digits >= DIGIT_LIMIT) begin
            digit_start = 4'(DIGIT_LIMIT);
        end else begin
            digit_start = s_digits[3:0];
        end
    end

    // Pick the highest size class whose threshold is met
    always_comb begin
        priority if (op_reg.volume >= vol_large_reg || amount_reg >= amt_large_reg) begin
            cls = 2'd3;
        end else if (op_reg.volume >= vol_medium_reg || amount_reg >= amt_medium_reg) begin
            cls = 2'd2;
        end else if (op_reg.volume >= vol_small_reg || amount_reg >= amt_small_reg) begin
            cls = 2'd1;
        end else begin
            cls = 2'd0;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);

    always_comb begin
        push_op     = op_reg;
        push_op.cls = cls;
    end

    // Sequence one item: load, scale, hand over
    always_comb begin
        state_next     = state_reg;
        amount_next    = amount_reg;
        digit_cnt_next = digit_cnt_reg;
        op_next        = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    amount_next    = amount_mul;
                    digit_cnt_next = digit_start;
                    op_next.action = action_t'(s_action);
                    op_next.sell   = s_direction[1];
                    op_next.split  = (s_direction == 2'sd0);
                    op_next.cls    = '0;
                    op_next.volume = s_volume;
                    state_next     = (digit_start == '0) ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV: begin
                amount_next    = amount_div;
                digit_cnt_next = digit_cnt_reg - 4'd1;
                if (digit_cnt_reg == 4'd1) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        amount_reg    <= amount_next;
        digit_cnt_reg <= digit_cnt_next;
        op_reg        <= op_next;
    end

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_small_reg  <= VOL_SMALL_RST;
            vol_medium_reg <= VOL_MEDIUM_RST;
            vol_large_reg  <= VOL_LARGE_RST;
            amt_small_reg  <= AMT_SMALL_RST;
            amt_medium_reg <= AMT_MEDIUM_RST;
            amt_large_reg  <= AMT_LARGE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VOL_SMALL:  vol_small_reg  <= cfg_wdata;
                REG_VOL_MEDIUM: vol_medium_reg <= cfg_wdata;
                REG_VOL_LARGE:  vol_large_reg  <= cfg_wdata;
                REG_AMT_SMALL:  amt_small_reg  <= cfg_wdata;
                REG_AMT_MEDIUM: amt_medium_reg <= cfg_wdata;
                REG_AMT_LARGE:  amt_large_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/osbs_queue.sv */
module osbs_queue import osbs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  op_t  push_op,
    output logic push_ready,
    output logic pop_valid,
    output op_t  pop_op,
    input  logic pop_ready
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/osbs_back.sv */
module osbs_back import osbs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    input  op_t                  pop_op,
    output logic                 pop_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [M_TDATA_W-1:0] m_data
);

    logic [STAT_W-1:0] buy_tot_reg  [NUM_CLASSES];
    logic [STAT_W-1:0] sell_tot_reg [NUM_CLASSES];
    logic [STAT_W-1:0] order_cnt_reg [2];
    logic [STAT_W-1:0] wd_tot_reg    [2];
    logic [STAT_W-1:0] buy_tot_next  [NUM_CLASSES];
    logic [STAT_W-1:0] sell_tot_next [NUM_CLASSES];
    logic [STAT_W-1:0] order_cnt_next [2];
    logic [STAT_W-1:0] wd_tot_next    [2];

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0]    half_volume;
    logic                 do_pop;

    assign pop_ready   = !m_valid_reg || m_ready;
    assign do_pop      = pop_valid && pop_ready;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign half_volume = pop_op.volume >> 1;

    // Apply one item to the statistics
    always_comb begin
        buy_tot_next   = buy_tot_reg;
        sell_tot_next  = sell_tot_reg;
        order_cnt_next = order_cnt_reg;
        wd_tot_next    = wd_tot_reg;
        unique case (pop_op.action)
            ACT_ORDER: begin
                if (pop_op.sell) begin
                    sell_tot_next[pop_op.cls] = sell_tot_reg[pop_op.cls] + pop_op.volume;
                end else begin
                    buy_tot_next[pop_op.cls] = buy_tot_reg[pop_op.cls] + pop_op.volume;
                end
                order_cnt_next[pop_op.sell] = order_cnt_reg[pop_op.sell] + 32'd1;
            end
            ACT_WITHDRAW: begin
                if (pop_op.split) begin
                    wd_tot_next[0] = wd_tot_reg[0] + half_volume;
                    wd_tot_next[1] = wd_tot_reg[1] + half_volume;
                end else begin
                    wd_tot_next[pop_op.sell] = wd_tot_reg[pop_op.sell] + pop_op.volume;
                end
            end
            ACT_CLEAR: begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    buy_tot_next[k]  = '0;
                    sell_tot_next[k] = '0;
                end
                for (int k = 0; k < 2; k++) begin
                    order_cnt_next[k] = '0;
                    wd_tot_next[k]    = '0;
                end
            end
            ACT_NONE: ;
            default: ;
        endcase
    end

    // Pack the updated totals, first total in the lowest bits
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            m_data_next[k * STAT_W +: STAT_W]                 = buy_tot_next[k];
            m_data_next[(NUM_CLASSES + k) * STAT_W +: STAT_W] = sell_tot_next[k];
        end
        m_data_next[BUY_CNT_LSB +: STAT_W]       = order_cnt_next[0];
        m_data_next[SELL_CNT_LSB +: STAT_W]      = order_cnt_next[1];
        m_data_next[10 * STAT_W +: STAT_W]       = wd_tot_next[0];
        m_data_next[11 * STAT_W +: STAT_W]       = wd_tot_next[1];
    end

    // Hold statistics and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                buy_tot_reg[k]  <= '0;
                sell_tot_reg[k] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                order_cnt_reg[k] <= '0;
                wd_tot_reg[k]    <= '0;
            end
            m_valid_reg <= 1'b0;
        end else if (do_pop) begin
            buy_tot_reg   <= buy_tot_next;
            sell_tot_reg  <= sell_tot_next;
            order_cnt_reg <= order_cnt_next;
            wd_tot_reg    <= wd_tot_next;
            m_valid_reg   <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* rtl/order_size_bucket_statistics.sv */
// Order-flow statistics. Each input transfer is a new order, a withdrawal or
// a clear, and each one yields exactly one result transfer carrying all twelve
// running totals after that item is applied. The front end loads an item and
// forms the wrapped price*volume product, does one reciprocal-multiply divide
// by ten per price digit (the digit count clamped to ten for orders and zero
// for other items), then classifies the item and hands it to a small queue.
// The back end applies one queued item per cycle, unless its result is held
// by m_tready, into a registered result, so the front end sets the sustained
// rate. Thresholds may be written only while the block is idle.
module order_size_bucket_statistics import osbs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] price, [63:32] volume, [71:64] price_digits
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [1:0] action, [3:2] direction
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // 32 bits each, lowest first: buy_class0..3_total, sell_class0..3_total,
    // buy_order_count, sell_order_count, buy_withdrawn_total,
    // sell_withdrawn_total
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    op_t  push_op, pop_op;

    osbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_action    (s_tuser[1:0]),
        .s_direction (s_tuser[3:2]),
        .s_price     (s_tdata[31:0]),
        .s_volume    (s_tdata[63:32]),
        .s_digits    (s_tdata[71:64]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push_valid  (push_valid),
        .push_op     (push_op),
        .push_ready  (push_ready)
    );

    osbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready)
    );

    osbs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_op    (pop_op),
        .pop_ready (pop_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata)
    );

endmodule

/* rtl/osbs_checker.sv */
`include "order_size_bucket_statistics_assert.svh"

module osbs_checker import osbs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STAT_W-1:0] order_sum;

    // Buy plus sell order count as shown on the result port
    assign order_sum = m_tdata[BUY_CNT_LSB +: STAT_W] + m_tdata[SELL_CNT_LSB +: STAT_W];

    `OSBS_ASSERT_NXT(a_out_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    `OSBS_ASSERT_NXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    `OSBS_ASSERT_NXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front end took two items back to back")

    `OSBS_ASSERT_IMP(a_order_step, m_tvalid && $past(m_tvalid && m_tready), order_sum == $past(order_sum) || order_sum == $past(order_sum) + 32'd1 || order_sum == '0, "order count moved by more than one item")

endmodule

bind order_size_bucket_statistics osbs_checker u_osbs_checker (.*);
